/* design/fme_pkg.sv */
// ----------------------------------------------------------------------------
// fme_pkg
// Shared types and constants for the fuzzy membership evaluator.
// ----------------------------------------------------------------------------
package fme_pkg;

    localparam int FME_EXP_ENTRIES = 256;
    localparam int DIV_BITS        = 15;
    localparam int DEN_W           = 27;

    localparam logic [15:0] ONE_Q15 = 16'h8000;

    localparam logic [1:0] SHAPE_TRI   = 2'd0;
    localparam logic [1:0] SHAPE_TRAP  = 2'd1;
    localparam logic [1:0] SHAPE_SAT   = 2'd2;
    localparam logic [1:0] SHAPE_GAUSS = 2'd3;

    localparam logic [2:0] REG_KIND = 3'd0;
    localparam logic [2:0] REG_A    = 3'd1;
    localparam logic [2:0] REG_B    = 3'd2;
    localparam logic [2:0] REG_C    = 3'd3;
    localparam logic [2:0] REG_D    = 3'd4;

    localparam logic [1:0] CLS_ZERO = 2'd0;
    localparam logic [1:0] CLS_ONE  = 2'd1;
    localparam logic [1:0] CLS_DIV  = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
        logic signed [15:0] d;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        logic [1:0] cls;
        logic       gauss;
        logic       err;
    } t_ctl;

endpackage

/* design/fuzzy_membership_evaluator.sv */
// ----------------------------------------------------------------------------
// fuzzy_membership_evaluator
// Fuzzifier: membership degree of a Q8.8 sample in one fuzzy set, Q1.15 result.
// o_valid follows a taken request through the front, divider, table and output registers.
// Throughput: one request per cycle; busy stays low, results cannot be held off.
// Depth is set by the 15-stage divider plus front, table and output stages.
// Reset (synchronous, active low) clears the set-up registers and all valid bits.
// EXP_ENTRIES must be a power of two.
// ----------------------------------------------------------------------------
module fuzzy_membership_evaluator #(
    parameter int EXP_ENTRIES = fme_pkg::FME_EXP_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_sample,
    output logic        o_valid,
    output logic [15:0] o_degree,
    output logic        o_param_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import fme_pkg::*;

    localparam int IDX_W = $clog2(EXP_ENTRIES);

    typedef logic [15:0] t_rom [EXP_ENTRIES];

    function automatic t_rom build_rom();
        logic [63:0] step;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] pw;
        t_rom        rom;
        step = (64'd8 << 30) / 64'(EXP_ENTRIES);
        term = 64'd1 << 30;
        sum  = term;
        pw   = term;
        for (int k = 1; k <= 16; k++) begin
            term = ((term * step) >> 30) / 64'(k);
            if (k % 2 == 1) sum = sum - term;
            else            sum = sum + term;
        end
        for (int i = 0; i < EXP_ENTRIES; i++) begin
            rom[i] = 16'((pw + (64'd1 << 14)) >> 15);
            pw     = (pw * sum + (64'd1 << 29)) >> 30;
        end
        return rom;
    endfunction

    localparam t_rom EXP_ROM = build_rom();

    t_cfg                r_cfg;
    t_ctl                w_fr_ctl, w_dv_ctl, r_rom_ctl;
    logic [DEN_W-1:0]    w_num, w_den;
    logic [DIV_BITS-1:0] w_q, r_rom_q;
    logic [15:0]         r_rom_data;
    logic [IDX_W-1:0]    w_idx;
    logic                r_valid;
    logic [15:0]         r_degree, n_degree;
    logic                r_err;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_KIND: r_cfg.kind <= i_cfg_data[1:0];
                REG_A:    r_cfg.a    <= i_cfg_data;
                REG_B:    r_cfg.b    <= i_cfg_data;
                REG_C:    r_cfg.c    <= i_cfg_data;
                REG_D:    r_cfg.d    <= i_cfg_data;
                default:  r_cfg      <= r_cfg;
            endcase
        end
    end

    fme_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (start && !busy),
        .i_sample (i_sample),
        .o_ctl    (w_fr_ctl),
        .o_num    (w_num),
        .o_den    (w_den)
    );

    fme_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_fr_ctl),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_ctl   (w_dv_ctl),
        .o_q     (w_q)
    );

    assign w_idx = w_q[DIV_BITS-1 -: IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_ctl <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_rom_ctl <= w_dv_ctl;
            r_valid   <= r_rom_ctl.valid;
        end
    end

    always_comb begin
        case (r_rom_ctl.cls)
            CLS_ONE: n_degree = ONE_Q15;
            CLS_DIV: n_degree = r_rom_ctl.gauss ? r_rom_data : {1'b0, r_rom_q};
            default: n_degree = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rom_q    <= w_q;
        r_rom_data <= EXP_ROM[w_idx];
        r_degree   <= n_degree;
        r_err      <= r_rom_ctl.err;
    end

    assign o_valid       = r_valid;
    assign o_degree      = r_degree;
    assign o_param_error = r_err;

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_degree <= ONE_Q15)
        else $error("degree above one");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_param_error) |-> o_degree == 16'd0)
        else $error("error with nonzero degree");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##21 o_valid)
        else $error("request lost");
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(start, 21))
        else $error("result without request");

endmodule

/* design/fme_front.sv */
// ----------------------------------------------------------------------------
// fme_front
// Sample register, flank selection, squared distance and divider operand set-up.
// ----------------------------------------------------------------------------
module fme_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  fme_pkg::t_cfg           i_cfg,
    input  logic                    i_valid,
    input  logic [15:0]             i_sample,
    output fme_pkg::t_ctl           o_ctl,
    output logic [fme_pkg::DEN_W-1:0] o_num,
    output logic [fme_pkg::DEN_W-1:0] o_den
);
    import fme_pkg::*;

    logic              r0_valid;
    logic [15:0]       r0_x;

    t_ctl              r1_ctl, n1_ctl;
    logic [15:0]       r1_num, n1_num;
    logic [15:0]       r1_den, n1_den;
    logic [15:0]       r1_mag, n1_mag;

    t_ctl              r2_ctl;
    logic [15:0]       r2_num;
    logic [15:0]       r2_den;
    logic [31:0]       r2_prod;

    t_ctl              r3_ctl, n3_ctl;
    logic [DEN_W-1:0]  r3_num, n3_num;
    logic [DEN_W-1:0]  r3_den, n3_den;

    logic signed [17:0] xs, as, bs, cs, ds, rn, rd, diff;
    logic [1:0]         pc;
    logic [31:0]        wlim;

    assign xs = {{2{r0_x[15]}}, r0_x};
    assign as = {{2{i_cfg.a[15]}}, i_cfg.a};
    assign bs = {{2{i_cfg.b[15]}}, i_cfg.b};
    assign cs = {{2{i_cfg.c[15]}}, i_cfg.c};
    assign ds = {{2{i_cfg.d[15]}}, i_cfg.d};

    always_comb begin
        rn = '0;
        rd = '0;
        pc = CLS_ZERO;
        unique case (i_cfg.kind)
            SHAPE_TRI: begin
                if (xs <= as || xs >= cs) begin
                    pc = CLS_ZERO;
                end else if (xs <= bs) begin
                    rn = xs - as; rd = bs - as; pc = CLS_DIV;
                end else begin
                    rn = cs - xs; rd = cs - bs; pc = CLS_DIV;
                end
            end
            SHAPE_TRAP: begin
                if (xs <= as || xs >= ds) begin
                    pc = CLS_ZERO;
                end else if (xs <= bs) begin
                    rn = xs - as; rd = bs - as; pc = CLS_DIV;
                end else if (xs <= cs) begin
                    pc = CLS_ONE;
                end else begin
                    rn = ds - xs; rd = ds - cs; pc = CLS_DIV;
                end
            end
            SHAPE_SAT: begin
                if (as < bs) begin
                    if (xs <= as) begin
                        pc = CLS_ONE;
                    end else if (xs >= bs) begin
                        pc = CLS_ZERO;
                    end else begin
                        rn = bs - xs; rd = bs - as; pc = CLS_DIV;
                    end
                end else begin
                    if (xs >= as) begin
                        pc = CLS_ONE;
                    end else if (xs <= bs) begin
                        pc = CLS_ZERO;
                    end else begin
                        rn = xs - bs; rd = as - bs; pc = CLS_DIV;
                    end
                end
            end
            default: begin
                pc = CLS_ZERO;
            end
        endcase

        n1_ctl.cls = pc;
        if (pc == CLS_DIV) begin
            if (rd <= 18'sd0 || rn <= 18'sd0) begin
                n1_ctl.cls = CLS_ZERO;
            end else if (rn >= rd) begin
                n1_ctl.cls = CLS_ONE;
            end
        end
        n1_ctl.valid = r0_valid;
        n1_ctl.gauss = (i_cfg.kind == SHAPE_GAUSS);
        n1_ctl.err   = (i_cfg.kind == SHAPE_GAUSS) && (i_cfg.b <= 16'sd0);
        n1_num = rn[15:0];
        n1_den = rd[15:0];
        diff   = xs - as;
        n1_mag = diff[17] ? 16'(-diff) : diff[15:0];
    end

    assign wlim = {5'd0, i_cfg.b[14:0], 12'd0};

    always_comb begin
        n3_ctl = r2_ctl;
        n3_num = {11'd0, r2_num};
        n3_den = {11'd0, r2_den};
        if (r2_ctl.gauss) begin
            n3_num = r2_prod[DEN_W-1:0];
            n3_den = wlim[DEN_W-1:0];
            if (r2_ctl.err || r2_prod >= wlim) begin
                n3_ctl.cls = CLS_ZERO;
            end else begin
                n3_ctl.cls = CLS_DIV;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_ctl   <= '0;
            r2_ctl   <= '0;
            r3_ctl   <= '0;
        end else begin
            r0_valid <= i_valid;
            r1_ctl   <= n1_ctl;
            r2_ctl   <= r1_ctl;
            r3_ctl   <= n3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_x    <= i_sample;
        r1_num  <= n1_num;
        r1_den  <= n1_den;
        r1_mag  <= n1_mag;
        r2_num  <= r1_num;
        r2_den  <= r1_den;
        r2_prod <= 32'(r1_mag) * 32'(r1_mag);
        r3_num  <= n3_num;
        r3_den  <= n3_den;
    end

    assign o_ctl = r3_ctl;
    assign o_num = r3_num;
    assign o_den = r3_den;

endmodule

/* design/fme_div.sv */
// ----------------------------------------------------------------------------
// fme_div
// Pipelined restoring divider, one quotient bit per stage, fraction num/den.
// ----------------------------------------------------------------------------
module fme_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fme_pkg::t_ctl               i_ctl,
    input  logic [fme_pkg::DEN_W-1:0]   i_num,
    input  logic [fme_pkg::DEN_W-1:0]   i_den,
    output fme_pkg::t_ctl               o_ctl,
    output logic [fme_pkg::DIV_BITS-1:0] o_q
);
    import fme_pkg::*;

    t_ctl                r_ctl [DIV_BITS];
    logic [DEN_W-1:0]    r_rem [DIV_BITS];
    logic [DEN_W-1:0]    r_den [DIV_BITS];
    logic [DIV_BITS-1:0] r_q   [DIV_BITS];

    t_ctl                p_ctl [DIV_BITS];
    logic [DEN_W-1:0]    p_rem [DIV_BITS];
    logic [DEN_W-1:0]    p_den [DIV_BITS];
    logic [DIV_BITS-1:0] p_q   [DIV_BITS];

    logic [DEN_W-1:0]    n_rem [DIV_BITS];
    logic [DIV_BITS-1:0] n_q   [DIV_BITS];

    genvar s;
    generate
        for (s = 0; s < DIV_BITS; s++) begin : g_stage
            logic [DEN_W:0] t;
            logic           ge;
            if (s == 0) begin : g_first
                assign p_ctl[s] = i_ctl;
                assign p_rem[s] = i_num;
                assign p_den[s] = i_den;
                assign p_q[s]   = '0;
            end else begin : g_next
                assign p_ctl[s] = r_ctl[s-1];
                assign p_rem[s] = r_rem[s-1];
                assign p_den[s] = r_den[s-1];
                assign p_q[s]   = r_q[s-1];
            end
            assign t        = {p_rem[s], 1'b0};
            assign ge       = t >= {1'b0, p_den[s]};
            assign n_rem[s] = ge ? DEN_W'(t - {1'b0, p_den[s]}) : t[DEN_W-1:0];
            assign n_q[s]   = {p_q[s][DIV_BITS-2:0], ge};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DIV_BITS; i++) begin
            if (!i_rst_n) begin
                r_ctl[i] <= '0;
            end else begin
                r_ctl[i] <= p_ctl[i];
            end
            r_rem[i] <= n_rem[i];
            r_den[i] <= p_den[i];
            r_q[i]   <= n_q[i];
        end
    end

    assign o_ctl = r_ctl[DIV_BITS-1];
    assign o_q   = r_q[DIV_BITS-1];

endmodule
